// ===== sv/first_fit_segment_allocator_assert.svh =====
// Assertion macros for the first-fit segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define FFSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define FFSA_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/ffsa_pkg.sv =====
// Types and constants shared by the first-fit segment allocator modules.
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic RegRegionStart = 1'b0;
  localparam logic RegRegionEnd   = 1'b1;

  localparam logic [31:0] RegionStartReset = 32'h0000_0000;
  localparam logic [31:0] RegionEndReset   = 32'h0001_0000;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNoSpace   = 2'd1,
    StTableFull = 2'd2,
    StNotFound  = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] region_start;
    logic [31:0] region_end;
  } ffsa_cfg_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] seg_address;
    logic [31:0] high_water;
    logic [5:0]  used_count;
  } ffsa_res_t;

endpackage

`default_nettype wire

// ===== sv/ffsa_seg_mem.sv =====
// Segment table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ffsa_seg_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/ffsa_cfg_regs.sv =====
// APB-style configuration registers holding the managed region bounds.
`timescale 1ns / 1ps
`default_nettype none

module ffsa_cfg_regs
  import ffsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output ffsa_cfg_t        cfg_o
);

  logic [31:0] region_start_q;
  logic [31:0] region_end_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Only bit 2 of the address selects a register; the low bits are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= RegionStartReset;
      region_end_q   <= RegionEndReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegRegionStart: region_start_q <= pwdata;
        RegRegionEnd:   region_end_q   <= pwdata;
        default:        region_end_q   <= region_end_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRegionStart: prdata = region_start_q;
      RegRegionEnd:   prdata = region_end_q;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.region_start = region_start_q;
  assign cfg_o.region_end   = region_end_q;

endmodule

`default_nettype wire

// ===== sv/ffsa_engine.sv =====
// Command sequencer: scans, shifts and rewrites the segment table in memory.
`timescale 1ns / 1ps
`default_nettype none

module ffsa_engine
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ffsa_cfg_t        cfg_i,
  input  wire logic        start_i,
  input  wire logic        cmd_i,
  input  wire logic [15:0] alloc_size_i,
  input  wire logic [31:0] free_start_i,
  output logic             busy_o,
  output ffsa_res_t        res_o
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W = 48;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StScan   = 6'b000010,
    StDecide = 6'b000100,
    StInsSh  = 6'b001000,
    StInsWr  = 6'b010000,
    StDelSh  = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [CNT_W-1:0] ci_q, ci_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0] high_q, high_d;
  logic [32:0] cand_q, cand_d;
  logic        cmd_q;
  logic [15:0] size_q;
  logic [31:0] fstart_q;
  ffsa_res_t   res_q, res_d;

  logic             accept;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [ENT_W-1:0] mem_rdata;
  logic [31:0]      rd_start;
  logic [15:0]      rd_size;

  logic [33:0]      gap;
  logic             fits;
  logic [32:0]      next_cand;
  logic [33:0]      end_sum;
  logic             no_space;
  logic [CNT_W-1:0] ci_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] wr_dec;
  logic [CNT_W-1:0] wr_dec2;
  logic [CNT_W-1:0] wr_inc;
  logic [CNT_W-1:0] wr_inc2;

  // Round up to a multiple of 4; inputs stay below 2^33 - 3.
  function automatic logic [32:0] align4(logic [32:0] a);
    logic [32:0] s;
    s = a + 33'd3;
    return {s[32:2], 2'b00};
  endfunction

  ffsa_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept   = start_i & (state_q == StIdle);
  assign busy_o   = (state_q != StIdle);
  assign res_o    = res_q;
  assign rd_start = mem_rdata[47:16];
  assign rd_size  = mem_rdata[15:0];

  // The candidate is kept aligned, so the fit test is one subtract and compare.
  assign gap       = {2'b00, rd_start} - {1'b0, cand_q};
  assign fits      = !gap[33] && (gap[32:0] >= {17'b0, size_q});
  assign next_cand = align4({1'b0, rd_start} + {17'b0, rd_size});
  assign end_sum   = {1'b0, cand_q} + {18'b0, size_q};
  assign no_space  = end_sum > {2'b00, cfg_i.region_end};

  assign ci_inc  = ci_q + CNT_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign wr_dec  = wr_q - CNT_W'(1);
  assign wr_dec2 = wr_q - CNT_W'(2);
  assign wr_inc  = wr_q + CNT_W'(1);
  assign wr_inc2 = wr_q + CNT_W'(2);

  always_comb begin
    state_d   = state_q;
    ci_d      = ci_q;
    wr_d      = wr_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    high_d    = high_q;
    cand_d    = cand_q;
    res_d     = res_q;
    res_d.valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_q[IDX_W-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;

    unique case (state_q)
      StIdle: begin
        // Entry 0 is read here so that the scan sees it in its first cycle.
        if (start_i) begin
          ci_d   = '0;
          cand_d = align4({1'b0, cfg_i.region_start});
          if (cnt_q != '0) begin
            state_d = StScan;
          end else if (cmd_i == CmdAlloc) begin
            pos_d   = '0;
            state_d = StDecide;
          end else begin
            res_d.valid       = 1'b1;
            res_d.status      = StNotFound;
            res_d.seg_address = '0;
            res_d.high_water  = high_q;
            res_d.used_count  = 6'(cnt_q);
          end
        end
      end

      StScan: begin
        // The next entry is fetched while this one is checked.
        mem_raddr = ci_inc[IDX_W-1:0];
        if (cmd_q == CmdAlloc) begin
          if (fits) begin
            pos_d   = ci_q;
            state_d = StDecide;
          end else begin
            cand_d = next_cand;
            if (ci_inc == cnt_q) begin
              pos_d   = cnt_q;
              state_d = StDecide;
            end else begin
              ci_d = ci_inc;
            end
          end
        end else begin
          if (rd_start == fstart_q) begin
            if (ci_inc == cnt_q) begin
              cnt_d             = cnt_dec;
              res_d.valid       = 1'b1;
              res_d.status      = StOk;
              res_d.seg_address = '0;
              res_d.high_water  = high_q;
              res_d.used_count  = 6'(cnt_dec);
              state_d           = StIdle;
            end else begin
              wr_d    = ci_q;
              state_d = StDelSh;
            end
          end else if (ci_inc == cnt_q) begin
            res_d.valid       = 1'b1;
            res_d.status      = StNotFound;
            res_d.seg_address = '0;
            res_d.high_water  = high_q;
            res_d.used_count  = 6'(cnt_q);
            state_d           = StIdle;
          end else begin
            ci_d = ci_inc;
          end
        end
      end

      StDecide: begin
        mem_raddr = cnt_dec[IDX_W-1:0];
        if (no_space || (cnt_q >= CNT_W'(MAX_SEGMENTS))) begin
          res_d.valid       = 1'b1;
          res_d.status      = no_space ? StNoSpace : StTableFull;
          res_d.seg_address = '0;
          res_d.high_water  = high_q;
          res_d.used_count  = 6'(cnt_q);
          state_d           = StIdle;
        end else if (pos_q == cnt_q) begin
          state_d = StInsWr;
        end else begin
          wr_d    = cnt_q;
          state_d = StInsSh;
        end
      end

      StInsSh: begin
        // Move entries up one place, from the top down to the insert point.
        mem_we    = 1'b1;
        mem_waddr = wr_q[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = wr_dec2[IDX_W-1:0];
        if (wr_dec == pos_q) begin
          state_d = StInsWr;
        end else begin
          wr_d = wr_dec;
        end
      end

      StInsWr: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IDX_W-1:0];
        mem_wdata = {cand_q[31:0], size_q};
        cnt_d     = cnt_inc;
        if (end_sum[31:0] > high_q) begin
          high_d = end_sum[31:0];
        end
        res_d.valid       = 1'b1;
        res_d.status      = StOk;
        res_d.seg_address = cand_q[31:0];
        res_d.high_water  = high_d;
        res_d.used_count  = 6'(cnt_inc);
        state_d           = StIdle;
      end

      StDelSh: begin
        // Move entries down one place over the freed slot.
        mem_we    = 1'b1;
        mem_waddr = wr_q[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = wr_inc2[IDX_W-1:0];
        if (wr_inc2 == cnt_q) begin
          cnt_d             = cnt_dec;
          res_d.valid       = 1'b1;
          res_d.status      = StOk;
          res_d.seg_address = '0;
          res_d.high_water  = high_q;
          res_d.used_count  = 6'(cnt_dec);
          state_d           = StIdle;
        end else begin
          wr_d = wr_inc;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ci_q    <= '0;
      wr_q    <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      high_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      ci_q    <= ci_d;
      wr_q    <= wr_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    if (accept) begin
      cmd_q    <= cmd_i;
      size_q   <= alloc_size_i;
      fstart_q <= free_start_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/first_fit_segment_allocator.sv =====
// Allocate: a scan finds the first gap that fits, a decide step checks region space and table
// capacity (a failure ends there), entries from the insert point up shift up and the new entry is
// written. Free: a scan for the start address, then a shift down unless the last entry matched;
// busy stays low on an empty table. One entry is read per cycle. done_o pulses right after busy
// falls and a new word may start then. Reset (rst_ni low, asynchronous) empties the table,
// clears the high-water mark and restores the region registers; table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_segment_allocator_assert.svh"

module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd_i,
  input  wire logic [15:0] alloc_size_i,
  input  wire logic [31:0] free_start_i,
  output logic             done_o,
  output logic      [1:0]  status_o,
  output logic      [31:0] seg_address_o,
  output logic      [31:0] high_water_o,
  output logic      [5:0]  used_count_o
);

  ffsa_cfg_t cfg;
  ffsa_res_t res;
  logic      fail_word;
  logic      miss_word;

  ffsa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffsa_engine #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start_i      (start),
    .cmd_i        (cmd_i),
    .alloc_size_i (alloc_size_i),
    .free_start_i (free_start_i),
    .busy_o       (busy),
    .res_o        (res)
  );

  assign done_o        = res.valid;
  assign status_o      = res.status;
  assign seg_address_o = res.seg_address;
  assign high_water_o  = res.high_water;
  assign used_count_o  = res.used_count;

  assign fail_word = done_o && (status_o != StOk);
  assign miss_word = done_o && (status_o == StNotFound);

  `FFSA_ASSERT_NR(a_done_not_busy, done_o |-> !busy, "result word while busy")
  `FFSA_ASSERT(a_fail_addr_zero, fail_word |-> (seg_address_o == '0), "address on failure")
  `FFSA_ASSERT(a_high_water_mono, high_water_o >= $past(high_water_o), "high-water fell")
  `FFSA_ASSERT(a_not_found_count, miss_word |-> $stable(used_count_o), "count moved")

endmodule

`default_nettype wire
